// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the range histogram.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Cause at one edge implies effect at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) else $error(msg);
`endif

// ----- rtl/arsh_pkg.sv -----
// Types and fixed field widths of the address range histogram.
// No dependencies; used by the interfaces, the cells and the top level.
package arsh_pkg;

	localparam int OPCODE_W     = 2;
	localparam int SLOT_FIELD_W = 4;
	localparam int SHIFT_W      = 6;
	localparam int TOTAL_W      = 9;
	localparam int BSEL_W       = 8;
	localparam int RFOUND_W     = 4;
	localparam int BFOUND_W     = 8;
	localparam int REGCNT_W     = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Control part of the token that walks the cell chain.
	typedef struct packed {
		logic                    valid;
		op_t                     op;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [SHIFT_W-1:0]      shift;
		logic [TOTAL_W-1:0]      total;
		logic [BSEL_W-1:0]       bsel;
		logic                    found;
		logic [SHIFT_W-1:0]      fshift;
		logic [TOTAL_W-1:0]      ftotal;
	} tok_ctl_t;

endpackage

// ----- rtl/arsh_ifs.sv -----
// Valid/ready channel interfaces of the range histogram: request, response, config.
// Depends on arsh_pkg for the fixed field widths.
interface arsh_req_if #(parameter int ADDR_BITS = 48);
	logic                                valid;
	logic                                ready;
	logic [arsh_pkg::OPCODE_W-1:0]       opcode;
	logic [arsh_pkg::SLOT_FIELD_W-1:0]   slot;
	logic [ADDR_BITS-1:0]                region_first;
	logic [ADDR_BITS-1:0]                region_limit;
	logic [arsh_pkg::SHIFT_W-1:0]        bucket_shift;
	logic [arsh_pkg::TOTAL_W-1:0]        bucket_total;
	logic [ADDR_BITS-1:0]                sample_address;
	logic [arsh_pkg::BSEL_W-1:0]         bucket_select;

	modport source (output valid, opcode, slot, region_first, region_limit, bucket_shift,
		bucket_total, sample_address, bucket_select, input ready);
	modport sink (input valid, opcode, slot, region_first, region_limit, bucket_shift,
		bucket_total, sample_address, bucket_select, output ready);
endinterface

interface arsh_rsp_if #(parameter int COUNT_BITS = 32);
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic [arsh_pkg::RFOUND_W-1:0]     region_found;
	logic [arsh_pkg::BFOUND_W-1:0]     bucket_found;
	logic [COUNT_BITS-1:0]             count_value;

	modport source (output valid, hit, region_found, bucket_found, count_value, input ready);
	modport sink (input valid, hit, region_found, bucket_found, count_value, output ready);
endinterface

interface arsh_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [arsh_pkg::REGCNT_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/arsh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/arsh_cell.sv -----
// One region slot of the lookup chain: holds the region and matches the passing token.
// Depends on arsh_pkg for the token control struct.
module arsh_cell #(
	parameter int IDX       = 0,
	parameter int ADDR_BITS = 48,
	parameter int SLOT_W    = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     active,
	input  arsh_pkg::tok_ctl_t       prev_ctl,
	input  logic [ADDR_BITS-1:0]     prev_a,
	input  logic [ADDR_BITS-1:0]     prev_b,
	input  logic [SLOT_W-1:0]        prev_fslot,
	output arsh_pkg::tok_ctl_t       next_ctl,
	output logic [ADDR_BITS-1:0]     next_a,
	output logic [ADDR_BITS-1:0]     next_b,
	output logic [SLOT_W-1:0]        next_fslot
);

	localparam bit ADDRESSABLE = IDX < (1 << arsh_pkg::SLOT_FIELD_W);

	logic [ADDR_BITS-1:0]           start_q;
	logic [ADDR_BITS-1:0]           end_q;
	logic [arsh_pkg::SHIFT_W-1:0]   shift_q;
	logic [arsh_pkg::TOTAL_W-1:0]   total_q;
	logic                           valid_q;
	arsh_pkg::tok_ctl_t             ctl_q;
	logic [ADDR_BITS-1:0]           a_q;
	logic [ADDR_BITS-1:0]           b_q;
	logic [SLOT_W-1:0]              fslot_q;

	logic                           wr_here;
	logic                           hit_here;
	arsh_pkg::tok_ctl_t             ctl_d;

	assign wr_here = prev_ctl.valid && (prev_ctl.op == arsh_pkg::OP_WRITE) && ADDRESSABLE &&
		(prev_ctl.slot == arsh_pkg::SLOT_FIELD_W'(IDX));

	// Half-open match; the first matching slot claims the token.
	assign hit_here = prev_ctl.valid && (prev_ctl.op == arsh_pkg::OP_SAMPLE) &&
		!prev_ctl.found && active && (start_q <= prev_a) && (prev_a < end_q);

	always_comb begin
		ctl_d = prev_ctl;
		if (hit_here) begin
			ctl_d.found  = 1'b1;
			ctl_d.fshift = shift_q;
			ctl_d.ftotal = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			shift_q <= '0;
			total_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev_ctl.valid;
			if (wr_here) begin
				start_q <= prev_a;
				end_q   <= prev_b;
				shift_q <= prev_ctl.shift;
				total_q <= prev_ctl.total;
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_q   <= ctl_d;
		a_q     <= prev_a;
		b_q     <= hit_here ? (prev_a - start_q) : prev_b;
		fslot_q <= hit_here ? SLOT_W'(IDX) : prev_fslot;
	end

	always_comb begin
		next_ctl       = ctl_q;
		next_ctl.valid = valid_q;
	end
	assign next_a     = a_q;
	assign next_b     = b_q;
	assign next_fslot = fslot_q;

endmodule

// ----- rtl/address_range_sample_histogram.sv -----
// Address range sample histogram: top level with cell chain, bucket stage and counter RAM.
// Depends on arsh_pkg, arsh_ifs (channels), arsh_cell and arsh_ram.
// Usage:
//   request  - valid/ready channel; one transfer carries one operation:
//              write a region slot, sample an address, or read a counter.
//   response - valid/ready channel; exactly one result transfer per request.
//   cfg      - write-only channel for regions_in_use; always ready. Write
//              it only while no request is in flight.
// Flow: a request walks the chain of REGIONS region cells, one cell per
//   cycle; the bucket stage then registers the bucket shift and compare,
//   and the counter read-modify-write reads the counter RAM, writes back the
//   incremented count for a sample in range and loads the output register.
// Issue: one request at a time; a new request is accepted only after the
//   previous one has left the counter stage.
// Reset: region slots and regions_in_use clear at once; the counter RAM is
//   then cleared one entry a cycle, all REGIONS * BUCKETS entries (4096 at
//   the defaults), while request.ready stays low.
// Stall: the result sits in the output register until taken; a new request
//   is accepted meanwhile and its result waits at the counter stage until
//   the output register frees.
module address_range_sample_histogram #(
	parameter int REGIONS    = 16,
	parameter int BUCKETS    = 256,
	parameter int ADDR_BITS  = 48,
	parameter int COUNT_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	arsh_req_if.sink     request,
	arsh_rsp_if.source   response,
	arsh_cfg_if.sink     cfg
);

	localparam int SLOT_W    = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int BK_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int MEM_DEPTH = REGIONS * BUCKETS;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int CMP_W     = (ADDR_BITS > 17) ? ADDR_BITS : 17;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHAIN,
		S_BUCKET,
		S_RMW
	} state_t;

	state_t                          state_q;
	logic [MEM_AW-1:0]               clr_q;
	logic [arsh_pkg::REGCNT_W-1:0]   regions_q;

	// Output register
	logic                            out_valid_q;
	logic                            out_hit_q;
	logic [arsh_pkg::RFOUND_W-1:0]   out_region_q;
	logic [arsh_pkg::BFOUND_W-1:0]   out_bucket_q;
	logic [COUNT_BITS-1:0]           out_count_q;

	// Cell chain taps; tap 0 is the chain input, tap REGIONS its output
	arsh_pkg::tok_ctl_t              chain_ctl   [REGIONS+1];
	logic [ADDR_BITS-1:0]            chain_a     [REGIONS+1];
	logic [ADDR_BITS-1:0]            chain_b     [REGIONS+1];
	logic [SLOT_W-1:0]               chain_fslot [REGIONS+1];
	logic [REGIONS-1:0]              active;

	// Bucket stage
	arsh_pkg::op_t                   op_s1;
	logic                            found_s1;
	logic                            inrange_s1;
	logic                            rdok_s1;
	logic [SLOT_W-1:0]               fslot_s1;
	logic [BK_W-1:0]                 bucket_s1;
	logic [MEM_AW-1:0]               addr_s1;

	logic                            req_fire;
	logic                            cfg_fire;
	logic                            out_free;
	logic                            chain_done;
	arsh_pkg::tok_ctl_t              tail_ctl;
	logic [ADDR_BITS-1:0]            bucket_wide;
	logic [CMP_W-1:0]                lim_c;
	logic                            inrange_c;
	logic                            rdok_c;
	logic [SLOT_W-1:0]               idx_slot_c;
	logic [BK_W-1:0]                 idx_bucket_c;
	logic [MEM_AW-1:0]               addr_c;

	logic                            do_inc;
	logic                            do_rdok;
	logic                            leave_rmw;
	logic [COUNT_BITS-1:0]           rd_data;
	logic [COUNT_BITS-1:0]           inc_data;
	logic                            ram_we;
	logic [MEM_AW-1:0]               ram_waddr;
	logic [COUNT_BITS-1:0]           ram_wdata;
	logic                            ram_re;

	assign req_fire      = request.valid && request.ready;
	assign cfg_fire      = cfg.valid && cfg.ready;
	assign request.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign out_free      = !out_valid_q || response.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regions_q <= '0;
		end else if (cfg_fire) begin
			regions_q <= cfg.data;
		end
	end

	// Load the chain input with the accepted request
	always_comb begin
		chain_ctl[0].valid  = req_fire;
		chain_ctl[0].op     = arsh_pkg::op_t'(request.opcode);
		chain_ctl[0].slot   = request.slot;
		chain_ctl[0].shift  = request.bucket_shift;
		chain_ctl[0].total  = request.bucket_total;
		chain_ctl[0].bsel   = request.bucket_select;
		chain_ctl[0].found  = 1'b0;
		chain_ctl[0].fshift = '0;
		chain_ctl[0].ftotal = '0;
	end
	// A write carries first/limit; a sample carries its address on the a bus
	assign chain_a[0] = (arsh_pkg::op_t'(request.opcode) == arsh_pkg::OP_WRITE) ?
		request.region_first : request.sample_address;
	assign chain_b[0]     = request.region_limit;
	assign chain_fslot[0] = '0;

	for (genvar i = 0; i < REGIONS; i++) begin : g_cell
		assign active[i] = (32'(regions_q) > i);

		arsh_cell #(
			.IDX       (i),
			.ADDR_BITS (ADDR_BITS),
			.SLOT_W    (SLOT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.active     (active[i]),
			.prev_ctl   (chain_ctl[i]),
			.prev_a     (chain_a[i]),
			.prev_b     (chain_b[i]),
			.prev_fslot (chain_fslot[i]),
			.next_ctl   (chain_ctl[i+1]),
			.next_a     (chain_a[i+1]),
			.next_b     (chain_b[i+1]),
			.next_fslot (chain_fslot[i+1])
		);
	end

	assign tail_ctl   = chain_ctl[REGIONS];
	assign chain_done = tail_ctl.valid;

	// Bucket index from the offset the matching cell left on the b bus;
	// the limit is the region's bucket count, capped at BUCKETS.
	assign bucket_wide = chain_b[REGIONS] >> tail_ctl.fshift;
	assign lim_c = (CMP_W'(tail_ctl.ftotal) > CMP_W'(BUCKETS)) ?
		CMP_W'(BUCKETS) : CMP_W'(tail_ctl.ftotal);
	assign inrange_c = tail_ctl.found && (CMP_W'(bucket_wide) < lim_c);
	assign rdok_c = (32'(tail_ctl.slot) < REGIONS) && (32'(tail_ctl.bsel) < BUCKETS);

	assign idx_slot_c = (tail_ctl.op == arsh_pkg::OP_SAMPLE) ?
		chain_fslot[REGIONS] : SLOT_W'(tail_ctl.slot);
	assign idx_bucket_c = (tail_ctl.op == arsh_pkg::OP_SAMPLE) ?
		bucket_wide[BK_W-1:0] : BK_W'(tail_ctl.bsel);
	assign addr_c = MEM_AW'(idx_slot_c) * MEM_AW'(BUCKETS) + MEM_AW'(idx_bucket_c);

	always_ff @(posedge clk) begin
		if (chain_done) begin
			op_s1      <= tail_ctl.op;
			found_s1   <= tail_ctl.found;
			inrange_s1 <= inrange_c;
			rdok_s1    <= rdok_c;
			fslot_s1   <= chain_fslot[REGIONS];
			bucket_s1  <= bucket_wide[BK_W-1:0];
			addr_s1    <= addr_c;
		end
	end

	// Counter read-modify-write
	assign do_inc    = (op_s1 == arsh_pkg::OP_SAMPLE) && inrange_s1;
	assign do_rdok   = (op_s1 == arsh_pkg::OP_READ) && rdok_s1;
	assign leave_rmw = (state_q == S_RMW) && out_free;
	assign inc_data  = rd_data + COUNT_BITS'(1);

	assign ram_re    = (state_q == S_BUCKET);
	assign ram_we    = (state_q == S_CLEAR) || (leave_rmw && do_inc);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_s1;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : inc_data;

	arsh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MEM_DEPTH)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_s1),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == MEM_AW'(MEM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_CHAIN;
					end
				end
				S_CHAIN: begin
					if (chain_done) begin
						state_q <= S_BUCKET;
					end
				end
				S_BUCKET: begin
					state_q <= S_RMW;
				end
				S_RMW: begin
					// Hold the result here until the output register frees
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_hit_q    <= do_inc || do_rdok;
						out_region_q <= ((op_s1 == arsh_pkg::OP_SAMPLE) && found_s1) ?
							arsh_pkg::RFOUND_W'(fslot_s1) : '0;
						out_bucket_q <= do_inc ? arsh_pkg::BFOUND_W'(bucket_s1) : '0;
						out_count_q  <= do_inc ? inc_data : (do_rdok ? rd_data : '0);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign response.valid        = out_valid_q;
	assign response.hit          = out_hit_q;
	assign response.region_found = out_region_q;
	assign response.bucket_found = out_bucket_q;
	assign response.count_value  = out_count_q;

endmodule

// ----- rtl/arsh_checker.sv -----
// Port-level checks of the range histogram, bound to the top level.
// Depends on arsh_pkg, assert_macros.svh and the top level's channel ports.
`include "assert_macros.svh"

module arsh_checker #(
	parameter int COUNT_BITS = 32
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic                                rsp_hit,
	input logic [arsh_pkg::BFOUND_W-1:0]       rsp_bucket,
	input logic [COUNT_BITS-1:0]               rsp_count
);

	// A stalled result stays valid and holds its count and hit flag
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count) && $stable(rsp_hit), "stalled result changed")

	// A result without a hit reports no bucket and no count
	`ASSERT_HOLDS(a_miss_zero, clk, arst_n, rsp_valid && !rsp_hit |-> rsp_bucket == '0 && rsp_count == '0, "miss carries bucket or count")

	// Only one request is in flight
	`ASSERT_NEXT(a_one_flight, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")

	// No result appears right after a request transfer
	`ASSERT_NEXT(a_min_latency, clk, arst_n, req_valid && req_ready, !$rose(rsp_valid), "result too early")

endmodule

bind address_range_sample_histogram arsh_checker #(
	.COUNT_BITS (COUNT_BITS)
) u_arsh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (request.valid),
	.req_ready  (request.ready),
	.rsp_valid  (response.valid),
	.rsp_ready  (response.ready),
	.rsp_hit    (response.hit),
	.rsp_bucket (response.bucket_found),
	.rsp_count  (response.count_value)
);
